FILE: design/plot_correlation_track_initiator_defines.svh
// assertion macros for the plot correlation track initiator
// needs i_clk and i_rst_n in the scope where a macro is used
`ifndef PLOT_CORRELATION_TRACK_INITIATOR_DEFINES_SVH
`define PLOT_CORRELATION_TRACK_INITIATOR_DEFINES_SVH

// same-cycle property, off while reset is low
`define PCTI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition in one cycle implies consequence in the next
`define PCTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/pcti_pkg.sv
// shared types, constants and helpers of the plot correlation track initiator
// no dependencies
package pcti_pkg;

    localparam int GRID_BINS_DEF  = 32;
    localparam int CELL_SLOTS_DEF = 8;

    localparam logic [18:0] RADIUS_RST = 19'd1000;
    localparam logic [15:0] SCAN_RST   = 16'd2500;
    localparam logic [4:0]  NSCANS_RST = 5'd3;

    localparam logic [31:0] VEL_SCALE = 32'd1000;
    localparam logic signed [19:0] VMAX = 20'sd524287;
    localparam logic signed [19:0] VMIN = -20'sd524288;

    localparam int NB_COUNT = 9;

    // neighbour scan order, cell offsets
    localparam logic signed [1:0] NB_DX [NB_COUNT] = '{-2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1,
                                                        2'sd0, 2'sd0, 2'sd1, 2'sd1};
    localparam logic signed [1:0] NB_DY [NB_COUNT] = '{-2'sd1, 2'sd0, 2'sd1, -2'sd1, -2'sd1,
                                                        2'sd0, 2'sd1, 2'sd0, 2'sd1};

    typedef enum logic [1:0] {
        CFG_RADIUS = 2'd0,
        CFG_SCAN   = 2'd1,
        CFG_NSCANS = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_BX, S_BY, S_CELL, S_FILL, S_RD, S_EV, S_SQ, S_DEC, S_CNEXT,
        S_HOME, S_HFILL, S_SHRD, S_SHWR, S_WNEW, S_VX0, S_VX, S_VY, S_OUT
    } t_state;

    typedef struct packed {
        logic signed [19:0] pos_x;
        logic signed [19:0] pos_y;
        logic [31:0]        time_ms;
    } t_plot;

    typedef struct packed {
        logic               in_grid;
        logic               correlated;
        logic [7:0]         corr_count;
        logic signed [19:0] vel_x;
        logic signed [19:0] vel_y;
        logic               track_start;
        logic [15:0]        track_number;
        logic               cell_overflow;
    } t_result;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [31:0]        t;
        logic [7:0]         cnt;
    } t_entry;

    // magnitude of a 20-bit coordinate
    function automatic logic [19:0] abs20(input logic signed [19:0] v);
        logic [19:0] m;
        m = v[19] ? 20'(-v) : 20'(v);
        return m;
    endfunction

    // magnitude of a 21-bit difference
    function automatic logic [20:0] abs21(input logic signed [20:0] v);
        logic [20:0] m;
        m = v[20] ? 21'(-v) : 21'(v);
        return m;
    endfunction

    // signed velocity from quotient magnitude, saturated to 20 bits
    function automatic logic signed [19:0] vel_sat(input logic [31:0] q, input logic neg);
        logic signed [19:0] v;
        if (neg) begin
            v = (q > 32'd524288) ? VMIN : 20'(-$signed({1'b0, q[19:0]}));
        end else begin
            v = (q > 32'd524287) ? VMAX : $signed(q[19:0]);
        end
        return v;
    endfunction

endpackage

FILE: design/pcti_stream_if.sv
// valid/ready channel carrying one item of type T
// no dependencies
interface pcti_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

FILE: design/pcti_div.sv
// restoring divider, one quotient bit per cycle
// no package needed
module pcti_div #(
    parameter int DW = 32,
    parameter int VW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);
    localparam int CNW = (DW > 1) ? $clog2(DW) : 1;

    logic          r_busy;
    logic          r_done;
    logic [CNW-1:0] r_cnt;
    logic [DW-1:0] r_q;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_d;
    logic [VW:0]   shifted;
    logic          fits;

    // trial subtract of the next partial remainder
    always_comb begin
        shifted = {r_rem, r_q[DW-1]};
        fits    = (shifted >= {1'b0, r_d});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], fits};
            r_rem <= fits ? VW'(shifted - {1'b0, r_d}) : shifted[VW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

FILE: design/pcti_store.sv
// plot entry memory and per-cell fill count memory with clearing sweep
// depends on pcti_pkg
module pcti_store
    import pcti_pkg::*;
#(
    parameter int CW = 10,
    parameter int SW = 3,
    parameter int FW = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_clr,
    output logic            o_clr_busy,
    input  logic [CW-1:0]   i_fill_raddr,
    output logic [FW-1:0]   o_fill_rdata,
    input  logic            i_fill_we,
    input  logic [CW-1:0]   i_fill_waddr,
    input  logic [FW-1:0]   i_fill_wdata,
    input  logic [CW+SW-1:0] i_plot_raddr,
    output t_entry          o_plot_rdata,
    input  logic            i_plot_we,
    input  logic [CW+SW-1:0] i_plot_waddr,
    input  t_entry          i_plot_wdata
);
    logic [FW-1:0] fill_mem [1<<CW];
    t_entry        plot_mem [1<<(CW+SW)];

    logic          r_clr_busy;
    logic [CW-1:0] r_clr_addr;
    logic [FW-1:0] r_fill_rd;
    t_entry        r_plot_rd;

    // clearing sweep, one cell per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (i_clr) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {CW{1'b1}}) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // fill count memory
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            fill_mem[r_clr_addr] <= '0;
        end else if (i_fill_we) begin
            fill_mem[i_fill_waddr] <= i_fill_wdata;
        end
        r_fill_rd <= fill_mem[i_fill_raddr];
    end

    // plot entry memory
    always_ff @(posedge i_clk) begin
        if (i_plot_we) begin
            plot_mem[i_plot_waddr] <= i_plot_wdata;
        end
        r_plot_rd <= plot_mem[i_plot_raddr];
    end

    assign o_clr_busy   = r_clr_busy;
    assign o_fill_rdata = r_fill_rd;
    assign o_plot_rdata = r_plot_rd;
endmodule

FILE: design/plot_correlation_track_initiator.sv
// Plot correlation track initiator: bins radar plots into a grid held in a
// plot entry memory and a fill count memory, correlates against neighbor cells
// and declares tentative tracks. Depends on pcti_pkg, pcti_stream_if,
// pcti_div, pcti_store and the assertion macro header.
// One plot at a time. An accepted plot first passes the two bin divisions in
// the shared serial divider. Each of the nine neighbor cells then has its fill
// count read, and each stored entry in it passes the steps read, age and
// distance, square, and decide and write back through the memory's write port.
// Storing the plot reads the fill count of its own cell and, when that cell
// overflows, shifts the stored entries down one slot before the new entry is
// written. A correlated plot then passes the two velocity divisions, and the
// result is handed over. After reset, and after every write of search_radius,
// a clearing pass over all 2**(2*clog2(GRID_BINS)) cells (1024 by default)
// zeroes the fill counts; no plot is taken meanwhile.
// The result sits in an output register, so the next plot is taken while the
// previous result waits; the hand-over of a result stalls while an earlier
// result is still waiting.
`include "plot_correlation_track_initiator_defines.svh"

module plot_correlation_track_initiator
    import pcti_pkg::*;
#(
    parameter int GRID_BINS  = GRID_BINS_DEF,
    parameter int CELL_SLOTS = CELL_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [18:0] i_cfg_data,
    pcti_stream_if.sink   i_plot,
    pcti_stream_if.source o_res
);
    localparam int BW = $clog2(GRID_BINS);
    localparam int CW = 2 * BW;
    localparam int SW = (CELL_SLOTS > 1) ? $clog2(CELL_SLOTS) : 1;
    localparam int FW = $clog2(CELL_SLOTS + 1);
    localparam int IDX_OFF = (GRID_BINS - 2) / 2;
    localparam int DW = 32;
    localparam int VW = 20;

    t_state r_state, n_state;

    // configuration and persistent control
    logic [18:0] r_radius;
    logic [15:0] r_scan;
    logic [4:0]  r_nscans;
    logic [15:0] r_next_track;
    logic        r_oval;
    t_result     r_res;

    // per-plot working registers
    logic signed [19:0] r_px, r_py;
    logic [31:0]        r_pt;
    logic [BW-1:0]      r_bx, r_by;
    logic               r_bx_ok, r_ingrid;
    logic [3:0]         r_k;
    logic [CW-1:0]      r_cell;
    logic [FW-1:0]      r_fill, r_i, r_w, r_j;
    logic               r_mcell;
    t_entry             r_ent;
    logic               r_old, r_erase, r_young, r_inr;
    logic signed [20:0] r_dx, r_dy;
    logic [20:0]        r_adx, r_ady;
    logic [16:0]        r_age;
    logic [37:0]        r_sqx, r_sqy, r_r2;
    logic               r_corr, r_ovf;
    logic [7:0]         r_cnt;
    logic signed [20:0] r_mdx, r_mdy;
    logic [16:0]        r_vage;
    logic signed [19:0] r_vx, r_vy;

    // interconnect
    logic            clr_busy, clr_req, in_acc;
    logic [FW-1:0]   fill_rdata;
    t_entry          plot_rdata;
    logic [CW-1:0]   fill_raddr, fill_waddr;
    logic            fill_we;
    logic [FW-1:0]   fill_wdata;
    logic [CW+SW-1:0] plot_raddr, plot_waddr;
    logic            plot_we;
    t_entry          plot_wdata;
    logic            div_start, div_done;
    logic [DW-1:0]   div_dvd, div_quot;
    logic [VW-1:0]   div_dvs, div_rem;

    logic [18:0]        reff;
    logic [16:0]        seff;
    logic               bin_neg;
    logic signed [22:0] bin_q, bin_v;
    logic               bin_ok;
    logic [BW-1:0]      nb_x, nb_y;
    logic [CW-1:0]      nb_cell;
    logic signed [32:0] age;
    logic signed [34:0] age2, age35;
    logic signed [20:0] ev_dx, ev_dy;
    logic [20:0]        ev_adx, ev_ady;
    logic [38:0]        dist2;
    logic               match, keep;
    logic               tstart;

    assign reff   = (r_radius == '0) ? 19'd1 : r_radius;
    assign seff   = (r_scan == '0) ? 17'd1 : {1'b0, r_scan};
    assign in_acc = i_plot.valid && i_plot.ready;
    assign clr_req = i_cfg_we && (i_cfg_idx == CFG_RADIUS);
    assign i_plot.ready = (r_state == S_IDLE) && !clr_busy;
    assign o_res.valid   = r_oval;
    assign o_res.payload = r_res;

    // floor division result turned into a grid bin
    always_comb begin
        bin_neg = (r_state == S_BX) ? r_px[19] : r_py[19];
        bin_q   = $signed({2'b0, div_quot[20:0]});
        if (bin_neg) begin
            bin_q = -bin_q - ((div_rem != '0) ? 23'sd1 : 23'sd0);
        end
        bin_v  = bin_q + 23'(IDX_OFF + 1);
        bin_ok = (bin_v >= 23'sd1) && (bin_v <= 23'(GRID_BINS - 2));
    end

    // neighbor cell address
    always_comb begin
        nb_x    = r_bx + BW'(NB_DX[r_k]);
        nb_y    = r_by + BW'(NB_DY[r_k]);
        nb_cell = {nb_x, nb_y};
    end

    // age and offset of the entry just read
    always_comb begin
        age    = $signed({1'b0, r_pt}) - $signed({1'b0, plot_rdata.t});
        age35  = 35'(age);
        age2   = age35 <<< 1;
        ev_dx  = 21'(r_px) - 21'(plot_rdata.x);
        ev_dy  = 21'(r_py) - 21'(plot_rdata.y);
        ev_adx = abs21(ev_dx);
        ev_ady = abs21(ev_dy);
    end

    // gate decision for the entry under test
    always_comb begin
        dist2 = {1'b0, r_sqx} + {1'b0, r_sqy};
        match = !r_mcell && !r_old && !r_young && r_inr && (dist2 < {1'b0, r_r2});
        keep  = r_mcell || !(r_old && r_erase);
    end

    assign tstart = r_corr && (({1'b0, r_cnt} + 9'd1) >= {4'b0, r_nscans});

    // sequencer next state and memory/divider controls
    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dvs    = VW'(reff);
        fill_raddr = r_cell;
        fill_we    = 1'b0;
        fill_waddr = r_cell;
        fill_wdata = r_w;
        plot_raddr = {r_cell, r_i[SW-1:0]};
        plot_we    = 1'b0;
        plot_waddr = {r_cell, r_w[SW-1:0]};
        plot_wdata = r_ent;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    div_start = 1'b1;
                    div_dvd   = DW'(abs20(i_plot.payload.pos_x));
                    n_state   = S_BX;
                end
            end
            S_BX: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_dvd   = DW'(abs20(r_py));
                    n_state   = S_BY;
                end
            end
            S_BY: begin
                if (div_done) begin
                    n_state = (r_bx_ok && bin_ok) ? S_CELL : S_OUT;
                end
            end
            S_CELL: begin
                fill_raddr = nb_cell;
                n_state    = S_FILL;
            end
            S_FILL:  n_state = (fill_rdata == '0) ? S_CNEXT : S_RD;
            S_RD:    n_state = S_EV;
            S_EV:    n_state = S_SQ;
            S_SQ:    n_state = S_DEC;
            S_DEC: begin
                plot_we = keep;
                n_state = ((r_i + 1'b1) == r_fill) ? S_CNEXT : S_RD;
            end
            S_CNEXT: begin
                fill_we = 1'b1;
                n_state = (r_k == 4'(NB_COUNT - 1)) ? S_HOME : S_CELL;
            end
            S_HOME: begin
                fill_raddr = {r_bx, r_by};
                n_state    = S_HFILL;
            end
            S_HFILL: begin
                if (fill_rdata >= FW'(CELL_SLOTS) && CELL_SLOTS > 1) begin
                    n_state = S_SHRD;
                end else begin
                    n_state = S_WNEW;
                end
            end
            S_SHRD: begin
                plot_raddr = {r_cell, SW'(r_j + 1'b1)};
                n_state    = S_SHWR;
            end
            S_SHWR: begin
                plot_we    = 1'b1;
                plot_waddr = {r_cell, r_j[SW-1:0]};
                plot_wdata = plot_rdata;
                n_state    = ((r_j + 1'b1) == FW'(CELL_SLOTS - 1)) ? S_WNEW : S_SHRD;
            end
            S_WNEW: begin
                plot_we    = 1'b1;
                plot_waddr = {r_cell, r_fill[SW-1:0]};
                plot_wdata = '{x: r_px, y: r_py, t: r_pt, cnt: r_cnt};
                fill_we    = 1'b1;
                fill_wdata = r_fill + 1'b1;
                n_state    = r_corr ? S_VX0 : S_OUT;
            end
            S_VX0: begin
                div_start = 1'b1;
                div_dvd   = DW'({11'b0, abs21(r_mdx)} * VEL_SCALE);
                div_dvs   = VW'(r_vage);
                n_state   = S_VX;
            end
            S_VX: begin
                div_dvs = VW'(r_vage);
                if (div_done) begin
                    div_start = 1'b1;
                    div_dvd   = DW'({11'b0, abs21(r_mdy)} * VEL_SCALE);
                    n_state   = S_VY;
                end
            end
            S_VY: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_oval || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, configuration, track counter and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_radius     <= RADIUS_RST;
            r_scan       <= SCAN_RST;
            r_nscans     <= NSCANS_RST;
            r_next_track <= '0;
            r_oval       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_RADIUS: begin
                        r_radius     <= i_cfg_data;
                        r_next_track <= '0;
                    end
                    CFG_SCAN:   r_scan   <= i_cfg_data[15:0];
                    CFG_NSCANS: r_nscans <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (r_state == S_OUT && (!r_oval || o_res.ready)) begin
                r_oval <= 1'b1;
                if (tstart) begin
                    r_next_track <= r_next_track + 1'b1;
                end
            end else if (o_res.ready) begin
                r_oval <= 1'b0;
            end
        end
    end

    // per-plot datapath
    always_ff @(posedge i_clk) begin
        r_r2 <= reff * reff;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_px   <= i_plot.payload.pos_x;
                    r_py   <= i_plot.payload.pos_y;
                    r_pt   <= i_plot.payload.time_ms;
                    r_corr <= 1'b0;
                    r_cnt  <= '0;
                    r_ovf  <= 1'b0;
                    r_vx   <= '0;
                    r_vy   <= '0;
                    r_ingrid <= 1'b0;
                end
            end
            S_BX: begin
                if (div_done) begin
                    r_bx    <= bin_v[BW-1:0];
                    r_bx_ok <= bin_ok;
                end
            end
            S_BY: begin
                if (div_done) begin
                    r_by     <= bin_v[BW-1:0];
                    r_ingrid <= r_bx_ok && bin_ok;
                    r_k      <= '0;
                end
            end
            S_CELL: r_cell <= nb_cell;
            S_FILL: begin
                r_fill  <= fill_rdata;
                r_i     <= '0;
                r_w     <= '0;
                r_mcell <= 1'b0;
            end
            S_RD: ;
            S_EV: begin
                r_ent   <= plot_rdata;
                r_old   <= age2 > $signed(35'(3 * seff));
                r_erase <= age35 > $signed(35'(2 * seff));
                r_young <= age2 < $signed(35'(seff));
                r_age   <= age[16:0];
                r_dx    <= ev_dx;
                r_dy    <= ev_dy;
                r_adx   <= ev_adx;
                r_ady   <= ev_ady;
                r_inr   <= (ev_adx < {2'b0, reff}) && (ev_ady < {2'b0, reff});
            end
            S_SQ: begin
                r_sqx <= r_adx[18:0] * r_adx[18:0];
                r_sqy <= r_ady[18:0] * r_ady[18:0];
            end
            S_DEC: begin
                if (match) begin
                    r_corr  <= 1'b1;
                    r_cnt   <= (r_ent.cnt == 8'd255) ? 8'd255 : r_ent.cnt + 8'd1;
                    r_mdx   <= r_dx;
                    r_mdy   <= r_dy;
                    r_vage  <= r_age;
                    r_mcell <= 1'b1;
                end
                if (keep) begin
                    r_w <= r_w + 1'b1;
                end
                r_i <= r_i + 1'b1;
            end
            S_CNEXT: r_k <= r_k + 1'b1;
            S_HOME:  r_cell <= {r_bx, r_by};
            S_HFILL: begin
                r_j <= '0;
                if (fill_rdata >= FW'(CELL_SLOTS)) begin
                    r_fill <= FW'(CELL_SLOTS - 1);
                    r_ovf  <= 1'b1;
                end else begin
                    r_fill <= fill_rdata;
                end
            end
            S_SHRD: ;
            S_SHWR: r_j <= r_j + 1'b1;
            S_WNEW: ;
            S_VX0: ;
            S_VX: begin
                if (div_done) begin
                    r_vx <= vel_sat(div_quot, r_mdx[20]);
                end
            end
            S_VY: begin
                if (div_done) begin
                    r_vy <= vel_sat(div_quot, r_mdy[20]);
                end
            end
            S_OUT: begin
                if (!r_oval || o_res.ready) begin
                    r_res.in_grid       <= r_ingrid;
                    r_res.correlated    <= r_corr;
                    r_res.corr_count    <= r_cnt;
                    r_res.vel_x         <= r_vx;
                    r_res.vel_y         <= r_vy;
                    r_res.track_start   <= tstart;
                    r_res.track_number  <= tstart ? r_next_track : 16'd0;
                    r_res.cell_overflow <= r_ovf;
                end
            end
            default: ;
        endcase
    end

    pcti_div #(.DW(DW), .VW(VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    pcti_store #(.CW(CW), .SW(SW), .FW(FW)) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clr        (clr_req),
        .o_clr_busy   (clr_busy),
        .i_fill_raddr (fill_raddr),
        .o_fill_rdata (fill_rdata),
        .i_fill_we    (fill_we),
        .i_fill_waddr (fill_waddr),
        .i_fill_wdata (fill_wdata),
        .i_plot_raddr (plot_raddr),
        .o_plot_rdata (plot_rdata),
        .i_plot_we    (plot_we),
        .i_plot_waddr (plot_waddr),
        .i_plot_wdata (plot_wdata)
    );

    // checks on sequencing and result consistency
    `PCTI_ASSERT(a_no_plot_in_clear, (clr_busy |-> !i_plot.ready), "plot taken during clear")
    `PCTI_ASSERT_NEXT(a_clear_on_radius, clr_req, clr_busy, "radius write did not clear grid")
    `PCTI_ASSERT(a_ovf_in_grid, (r_oval && r_res.cell_overflow |-> r_res.in_grid), "overflow off grid")
    `PCTI_ASSERT(a_start_corr, (r_oval && r_res.track_start |-> r_res.correlated), "start uncorrelated")
    `PCTI_ASSERT(a_wb_behind_rd, (r_state == S_DEC |-> r_w <= r_i && r_i < r_fill), "compaction overrun")
endmodule
